/* rtl/lag_pkg.sv */
// Shared types, constants and saturation helper for the Laguerre tensor basis.
// Depends on nothing; every rtl file imports it.
package lag_pkg;

  localparam int unsigned MAX_DEGREE_DEF = 4;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ORD_W  = 3;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned ADDR_W = 3;

  // register map, index taken from paddr[ADDR_W-1]
  localparam logic [0:0] REG_MAX_DEGREE = 1'b0;
  localparam logic [ORD_W-1:0] MAX_DEGREE_RST = 3'd3;

  localparam int unsigned QUEUE_DEPTH = 2;

  // recurrence divider: clamped magnitude, bits resolved per cycle
  localparam int unsigned MAG_W      = 35;
  localparam int unsigned DIV_STEPS  = 7;
  localparam int unsigned DIV_CYCLES = MAG_W / DIV_STEPS;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t first_var;
    val_t second_var;
    val_t third_var;
  } lag_in_t;

  typedef struct packed {
    val_t             basis_value;
    logic [IDX_W-1:0] basis_index;
    logic [ORD_W-1:0] first_order;
    logic [ORD_W-1:0] second_order;
    logic [ORD_W-1:0] third_order;
    logic             saturated;
    logic             last;
  } lag_out_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [ORD_W-1:0] a_ord;
    logic [ORD_W-1:0] b_ord;
    logic [ORD_W-1:0] c_ord;
    logic             last;
  } lag_tag_t;

  typedef struct packed {
    val_t val;
    logic flag;
  } sat_t;

  // width of one queue entry: three value sets, their flags, the degree
  function automatic int unsigned entry_width(input int unsigned md);
    return 3 * (md + 1) * (VAL_W + 1) + ORD_W;
  endfunction

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.val  = SAT_MAX[VAL_W-1:0];
      r.flag = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val  = SAT_MIN[VAL_W-1:0];
      r.flag = 1'b1;
    end else begin
      r.val  = v[VAL_W-1:0];
      r.flag = 1'b0;
    end
    return r;
  endfunction

endpackage

/* rtl/laguerre_tensor_basis.sv */
// Top level of the Laguerre tensor-product basis evaluator: config register,
// front end, queue and back end. Depends on lag_pkg, lag_front, lag_queue, lag_back.
//
//   channel  direction  handshake                 payload
//   input    in         push / full               in_data_i  (lag_in_t)
//   result   out        empty / pop               out_data_o (lag_out_t)
//   config   in/out     psel penable pwrite pready paddr pwdata prdata
//
// Front: degree 0 or 1 needs no recurrence; for degree d >= 2 the sequencer runs
//   orders 2..d in turn, each with one multiply plus a serial divide by n.
// Back: one result per cycle unless a result is held, (d+1)(d+2)(d+3)/6 per input.
// Reset is asynchronous and clears control only; no clearing pass is needed.
// A stalled result freezes the back pipeline; a 2-entry queue lets the front run ahead.
module laguerre_tensor_basis import lag_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input items
  input  logic              push,
  output logic              full,
  input  lag_in_t           in_data_i,
  // result items
  output logic              empty,
  input  logic              pop,
  output lag_out_t          out_data_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  localparam int unsigned EW = entry_width(MAX_DEGREE);

  logic [ORD_W-1:0] max_degree_q;
  logic [ORD_W-1:0] deg_eff;
  logic             cfg_wr;

  logic          q_wr, q_full, q_rd, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;

  // APB: pready always high, register index in paddr[ADDR_W-1]
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[ADDR_W-1] == REG_MAX_DEGREE) ?
                  {{(CFG_W-ORD_W){1'b0}}, max_degree_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_degree_q <= MAX_DEGREE_RST;
    end else if (cfg_wr && paddr[ADDR_W-1] == REG_MAX_DEGREE) begin
      max_degree_q <= pwdata[ORD_W-1:0];
    end
  end

  // codes above the build limit (including the unused ones) run at the limit
  assign deg_eff = (max_degree_q > ORD_W'(MAX_DEGREE)) ? ORD_W'(MAX_DEGREE) : max_degree_q;

  lag_front #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_data_i (in_data_i),
    .deg_i     (deg_eff),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .q_data_o  (q_wdata)
  );

  lag_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  lag_back #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  // the final triple of an input is always (d, 0, 0)
  a_last_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.last) |->
      (out_data_o.second_order == '0 && out_data_o.third_order == '0))
    else $error("last result is not the (d,0,0) triple");

  // column 0 is always the constant term
  a_first_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.basis_index == '0) |->
      (out_data_o.first_order == '0 && out_data_o.second_order == '0 &&
       out_data_o.third_order == '0))
    else $error("column 0 is not the (0,0,0) triple");

  // total degree never exceeds the build limit
  a_deg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.first_order + out_data_o.second_order +
                out_data_o.third_order <= MAX_DEGREE))
    else $error("triple exceeds the maximum degree");
`endif

endmodule

/* rtl/lag_lane.sv */
// One variable's Laguerre recurrence: sequencer with a 32x32 multiplier and
// a serial divide-by-n unit. Depends on lag_pkg.
module lag_lane import lag_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  val_t                             x_i,
  input  logic [ORD_W-1:0]                 deg_i,
  output logic                             busy_o,
  output logic [MAX_DEGREE:0][VAL_W-1:0]   val_o,
  output logic [MAX_DEGREE:0]              flg_o
);

  localparam int unsigned SEL_W = $clog2(MAX_DEGREE + 1);
  localparam int unsigned CNT_W = $clog2(DIV_CYCLES);
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COEF = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_NUM  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [ORD_W-1:0] d_q, n_q;
  logic [CNT_W-1:0] cnt_q;

  val_t                         x_q;
  val_t                         coef_q;
  logic                         f_q;
  logic signed [63:0]           prod_q;
  logic signed [VAL_W+1:0]      wgt_q;
  logic                         neg_q;
  logic [MAG_W-1:0]             div_q;
  logic [1:0]                   rem_q;
  val_t                         prev1_q, prev2_q;
  logic                         pf1_q, pf2_q;
  logic [MAX_DEGREE:0][VAL_W-1:0] val_q;
  logic [MAX_DEGREE:0]          flg_q;

  logic signed [63:0]      x_in64, x64, coef_full, sh, wgt64, num_pos, num_neg, mag64;
  logic [3:0]              odd;
  logic [ORD_W-1:0]        nm1;
  logic signed [VAL_W+1:0] wgt_full;
  logic [MAG_W-1:0]        mag, div_nx;
  logic [1:0]              rem_nx;
  logic signed [MAG_W:0]   sq;
  sat_t                    l1, coef_s, nval;

  assign busy_o = (state_q != S_IDLE);
  assign val_o  = val_q;
  assign flg_o  = flg_q;

  // L1 = 1 - x
  assign x_in64 = $signed({{(64-VAL_W){x_i[VAL_W-1]}}, x_i});
  assign l1     = sat32(ONE - x_in64);

  // coefficient (2n-1) - x
  assign x64       = $signed({{(64-VAL_W){x_q[VAL_W-1]}}, x_q});
  assign odd       = {n_q, 1'b0} - 4'd1;
  assign coef_full = $signed({{(64-4){1'b0}}, odd} << FRAC_BITS) - x64;
  assign coef_s    = sat32(coef_full);

  // (n-1) * L(n-2)
  assign nm1      = n_q - ORD_W'(1);
  assign wgt_full = $signed({{2{prev2_q[VAL_W-1]}}, prev2_q}) * $signed({1'b0, nm1});

  // numerator, split into sign and clamped magnitude
  assign sh      = prod_q >>> FRAC_BITS;
  assign wgt64   = $signed({{(64-VAL_W-2){wgt_q[VAL_W+1]}}, wgt_q});
  assign num_pos = sh - wgt64;
  assign num_neg = wgt64 - sh;
  assign mag64   = num_pos[63] ? num_neg : num_pos;
  assign mag     = (|mag64[63:MAG_W]) ? '1 : mag64[MAG_W-1:0];

  // long division by n, quotient bits shift in as dividend bits shift out
  always_comb begin : div_step
    logic [2:0] t;
    rem_nx = rem_q;
    div_nx = div_q;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t = {rem_nx, div_nx[MAG_W-1]};
      if (t >= n_q) begin
        div_nx = {div_nx[MAG_W-2:0], 1'b1};
        rem_nx = 2'(t - n_q);
      end else begin
        div_nx = {div_nx[MAG_W-2:0], 1'b0};
        rem_nx = t[1:0];
      end
    end
  end

  assign sq   = neg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign nval = sat32($signed({{(63-MAG_W){sq[MAG_W]}}, sq}));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = (deg_i >= ORD_W'(2)) ? S_COEF : S_IDLE;
      end
      S_COEF: state_d = S_MUL;
      S_MUL:  state_d = S_NUM;
      S_NUM:  state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == CNT_W'(DIV_CYCLES - 1)) state_d = S_FIN;
      end
      S_FIN:  state_d = (n_q == d_q) ? S_IDLE : S_COEF;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      d_q     <= '0;
      n_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && start_i) begin
        d_q <= deg_i;
        n_q <= ORD_W'(2);
      end
      if (state_q == S_FIN) n_q <= n_q + ORD_W'(1);
      if (state_q == S_NUM) cnt_q <= '0;
      if (state_q == S_DIV) cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          x_q      <= x_i;
          val_q[0] <= ONE[VAL_W-1:0];
          flg_q[0] <= 1'b0;
          val_q[1] <= l1.val;
          flg_q[1] <= l1.flag;
          prev2_q  <= ONE[VAL_W-1:0];
          pf2_q    <= 1'b0;
          prev1_q  <= l1.val;
          pf1_q    <= l1.flag;
        end
      end
      S_COEF: begin
        coef_q <= coef_s.val;
        f_q    <= pf1_q | pf2_q | coef_s.flag;
      end
      S_MUL: begin
        prod_q <= coef_q * prev1_q;
        wgt_q  <= wgt_full;
      end
      S_NUM: begin
        neg_q <= num_pos[63];
        div_q <= mag;
        rem_q <= '0;
      end
      S_DIV: begin
        div_q <= div_nx;
        rem_q <= rem_nx;
      end
      S_FIN: begin
        val_q[n_q[SEL_W-1:0]] <= nval.val;
        flg_q[n_q[SEL_W-1:0]] <= f_q | nval.flag;
        prev2_q <= prev1_q;
        pf2_q   <= pf1_q;
        prev1_q <= nval.val;
        pf1_q   <= f_q | nval.flag;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/lag_front.sv */
// Front end: takes input transfers, runs three recurrence lanes and writes
// the finished polynomial sets into the queue. Depends on lag_pkg, lag_lane.
module lag_front import lag_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  output logic                                  full_o,
  input  lag_in_t                               in_data_i,
  input  logic [ORD_W-1:0]                      deg_i,
  input  logic                                  q_full_i,
  output logic                                  q_wr_o,
  output logic [entry_width(MAX_DEGREE)-1:0]    q_data_o
);

  logic                               busy_q;
  logic [ORD_W-1:0]                   deg_q;
  logic                               accept;
  logic [2:0]                         lane_busy;
  val_t                               lane_x [3];
  logic [2:0][MAX_DEGREE:0][VAL_W-1:0] lane_val;
  logic [2:0][MAX_DEGREE:0]           lane_flg;

  assign accept    = push_i & ~busy_q;
  assign full_o    = busy_q;
  assign lane_x[0] = in_data_i.first_var;
  assign lane_x[1] = in_data_i.second_var;
  assign lane_x[2] = in_data_i.third_var;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    lag_lane #(
      .MAX_DEGREE (MAX_DEGREE),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (accept),
      .x_i     (lane_x[g]),
      .deg_i   (deg_i),
      .busy_o  (lane_busy[g]),
      .val_o   (lane_val[g]),
      .flg_o   (lane_flg[g])
    );
  end

  // all lanes finished: hand the set over once the queue has room
  assign q_wr_o   = busy_q & ~(|lane_busy) & ~q_full_i;
  assign q_data_o = {deg_q, lane_flg, lane_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      deg_q  <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        deg_q  <= deg_i;
      end else if (q_wr_o) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

/* rtl/lag_queue.sv */
// Short queue of polynomial sets between front and back.
// Depends on lag_pkg for the default depth.
module lag_queue import lag_pkg::*; #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      case ({wr_i, rd_i})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

/* rtl/lag_back.sv */
// Back end: walks the degree triples of the queue head and forms the
// saturated triple products in a five-stage pipeline. Depends on lag_pkg.
module lag_back import lag_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_empty_i,
  input  logic [entry_width(MAX_DEGREE)-1:0] q_data_i,
  output logic                               q_rd_o,
  input  logic                               pop_i,
  output logic                               empty_o,
  output lag_out_t                           out_data_o
);

  localparam int unsigned SEL_W = $clog2(MAX_DEGREE + 1);

  logic [ORD_W-1:0]                    ent_deg;
  logic [2:0][MAX_DEGREE:0]            ent_flg;
  logic [2:0][MAX_DEGREE:0][VAL_W-1:0] ent_val;

  logic [ORD_W-1:0] a_q, b_q, c_q, sum_ab, sum_abc;
  logic [IDX_W-1:0] idx_q;
  logic             en, issue, fin;
  lag_tag_t         tag_c;

  logic     v0_q, v1_q, v2_q, v3_q, v4_q;
  val_t     s0_la_q, s0_lb_q, s0_lc_q, s1_lc_q, s2_lc_q, s2_p_q;
  logic     s0_f_q, s1_f_q, s2_f_q, s3_f_q;
  lag_tag_t s0_tag_q, s1_tag_q, s2_tag_q, s3_tag_q;
  logic signed [63:0] s1_prod_q, s3_prod_q;
  lag_out_t s4_q;
  sat_t     p1, p2;

  assign {ent_deg, ent_flg, ent_val} = q_data_i;

  // whole pipeline advances unless a finished result is held
  assign en     = ~v4_q | pop_i;
  assign issue  = en & ~q_empty_i;
  assign fin    = (a_q == ent_deg);
  assign q_rd_o = issue & fin;

  assign sum_ab  = a_q + b_q;
  assign sum_abc = sum_ab + c_q;

  assign tag_c.index = idx_q;
  assign tag_c.a_ord = a_q;
  assign tag_c.b_ord = b_q;
  assign tag_c.c_ord = c_q;
  assign tag_c.last  = fin;

  assign p1 = sat32(s1_prod_q >>> FRAC_BITS);
  assign p2 = sat32(s3_prod_q >>> FRAC_BITS);

  assign empty_o    = ~v4_q;
  assign out_data_o = s4_q;

  // triple walk: c inner, b middle, a outer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q   <= '0;
      b_q   <= '0;
      c_q   <= '0;
      idx_q <= '0;
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
    end else begin
      if (issue) begin
        if (fin) begin
          a_q   <= '0;
          b_q   <= '0;
          c_q   <= '0;
          idx_q <= '0;
        end else begin
          idx_q <= idx_q + IDX_W'(1);
          if (sum_abc != ent_deg) begin
            c_q <= c_q + ORD_W'(1);
          end else if (sum_ab != ent_deg) begin
            b_q <= b_q + ORD_W'(1);
            c_q <= '0;
          end else begin
            a_q <= a_q + ORD_W'(1);
            b_q <= '0;
            c_q <= '0;
          end
        end
      end
      if (en) begin
        v0_q <= issue;
        v1_q <= v0_q;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_la_q  <= ent_val[0][a_q[SEL_W-1:0]];
      s0_lb_q  <= ent_val[1][b_q[SEL_W-1:0]];
      s0_lc_q  <= ent_val[2][c_q[SEL_W-1:0]];
      s0_f_q   <= ent_flg[0][a_q[SEL_W-1:0]] | ent_flg[1][b_q[SEL_W-1:0]]
                | ent_flg[2][c_q[SEL_W-1:0]];
      s0_tag_q <= tag_c;

      s1_prod_q <= s0_la_q * s0_lb_q;
      s1_lc_q   <= s0_lc_q;
      s1_f_q    <= s0_f_q;
      s1_tag_q  <= s0_tag_q;

      s2_p_q   <= p1.val;
      s2_lc_q  <= s1_lc_q;
      s2_f_q   <= s1_f_q | p1.flag;
      s2_tag_q <= s1_tag_q;

      s3_prod_q <= s2_p_q * s2_lc_q;
      s3_f_q    <= s2_f_q;
      s3_tag_q  <= s2_tag_q;

      s4_q.basis_value  <= p2.val;
      s4_q.basis_index  <= s3_tag_q.index;
      s4_q.first_order  <= s3_tag_q.a_ord;
      s4_q.second_order <= s3_tag_q.b_ord;
      s4_q.third_order  <= s3_tag_q.c_ord;
      s4_q.saturated    <= s3_f_q | p2.flag;
      s4_q.last         <= s3_tag_q.last;
    end
  end

endmodule

/* verif/tb_top.sv */
// Self-checking bench for laguerre_tensor_basis: queue-style stimulus and result
// checks against an in-bench Laguerre tensor-basis predictor, plus config writes.
// Depends on rtl/lag_pkg.sv and rtl/laguerre_tensor_basis.sv.
`timescale 1ns / 1ps

module tb_top;
  import lag_pkg::*;

  localparam int    FRAC        = FRAC_BITS_DEF;
  localparam int    DEG_CAP     = MAX_DEGREE_DEF;
  localparam longint ONE_FX     = longint'(1) << FRAC_BITS_DEF;
  localparam int    CYCLE_LIMIT = 400000;
  // second register slot, not mapped in the block; writes there must be dropped
  localparam logic [0:0] REG_SPARE = 1'b1;

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              push      = 1'b0;
  logic              full;
  lag_in_t           in_data   = '0;
  logic              empty;
  logic              pop       = 1'b0;
  lag_out_t          out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [CFG_W-1:0]  pwdata    = '0;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  laguerre_tensor_basis dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  lag_in_t  queued_vars[$];    // items waiting for the driver
  lag_out_t pending_basis[$];  // predicted results, oldest first

  logic [ORD_W-1:0] cfg_degree = MAX_DEGREE_RST;  // mirror of max_degree register

  // per-variable polynomial values and saturation flags, orders 0..DEG_CAP
  longint lag_val [0:2][0:DEG_CAP];
  bit     lag_sat [0:2][0:DEG_CAP];

  int  items_queued   = 0;
  int  items_accepted = 0;
  int  results_seen   = 0;
  int  sat_seen       = 0;
  int  error_count    = 0;
  int  cycle_count    = 0;
  bit  in_taken       = 1'b0;  // transfer on the input side at the last rising edge
  bit  out_taken      = 1'b0;  // transfer on the result side at the last rising edge
  bit  tx_idle_on     = 1'b0;  // sender inserts random gaps
  bit  rx_idle_on     = 1'b0;  // receiver inserts random stalls
  int  tx_gap         = 0;
  int  rx_stall       = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point helpers
  // ---------------------------------------------------------------------------
  function automatic bit over32(input longint v);
    return (v > longint'(SAT_MAX)) || (v < longint'(SAT_MIN));
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > longint'(SAT_MAX)) return longint'(SAT_MAX);
    if (v < longint'(SAT_MIN)) return longint'(SAT_MIN);
    return v;
  endfunction

  // L0..Ld for one variable via the three-term recurrence. Products are
  // floored (>>> on signed), the divide by n truncates toward zero.
  task automatic eval_laguerre(input int v, input val_t x, input int d);
    longint xl, coef, num, quo;
    bit     f;
    xl = x;
    lag_val[v][0] = ONE_FX;
    lag_sat[v][0] = 1'b0;
    if (d >= 1) begin
      num = ONE_FX - xl;
      lag_sat[v][1] = over32(num);
      lag_val[v][1] = clamp32(num);
    end
    for (int n = 2; n <= d; n++) begin
      f    = lag_sat[v][n-1] | lag_sat[v][n-2];
      coef = longint'(2 * n - 1) * ONE_FX - xl;
      f    = f | over32(coef);
      coef = clamp32(coef);
      num  = ((coef * lag_val[v][n-1]) >>> FRAC) - longint'(n - 1) * lag_val[v][n-2];
      quo  = num / longint'(n);
      f    = f | over32(quo);
      lag_val[v][n] = clamp32(quo);
      lag_sat[v][n] = f;
    end
  endtask

  // Expected result list for one accepted item, appended in emission order.
  task automatic predict_basis(input lag_in_t item);
    int       d, col;
    bit       f;
    longint   p;
    lag_out_t r;
    d = (cfg_degree > DEG_CAP) ? DEG_CAP : int'(cfg_degree);
    eval_laguerre(0, item.first_var, d);
    eval_laguerre(1, item.second_var, d);
    eval_laguerre(2, item.third_var, d);
    col = 0;
    for (int a = 0; a <= d; a++) begin
      for (int b = 0; a + b <= d; b++) begin
        for (int c = 0; a + b + c <= d; c++) begin
          f = lag_sat[0][a] | lag_sat[1][b] | lag_sat[2][c];
          // (La*Lb) saturated, then times Lc, saturated again
          p = (lag_val[0][a] * lag_val[1][b]) >>> FRAC;
          f = f | over32(p);
          p = clamp32(p);
          p = (p * lag_val[2][c]) >>> FRAC;
          f = f | over32(p);
          p = clamp32(p);
          r.basis_value  = p[VAL_W-1:0];
          r.basis_index  = col[IDX_W-1:0];
          r.first_order  = a[ORD_W-1:0];
          r.second_order = b[ORD_W-1:0];
          r.third_order  = c[ORD_W-1:0];
          r.saturated    = f;
          r.last         = (a == d);
          pending_basis.push_back(r);
          col++;
        end
      end
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    error_count++;
    $display("[%0d] mismatch %s: got %0h want %0h (result #%0d)",
             cycle_count, what, got, want, results_seen);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge, predict and compare
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    lag_out_t want;
    cycle_count++;
    in_taken  = rst_ni && push && !full;
    out_taken = rst_ni && pop && !empty;
    if (in_taken) begin
      items_accepted++;
      predict_basis(in_data);
    end
    if (out_taken) begin
      results_seen++;
      if (pending_basis.size() == 0) begin
        note_mismatch("result with nothing expected", out_data.basis_value, '0);
      end else begin
        want = pending_basis.pop_front();
        if (want.saturated) sat_seen++;
        if (out_data.basis_value !== want.basis_value)
          note_mismatch("basis_value", out_data.basis_value, want.basis_value);
        if (out_data.basis_index !== want.basis_index)
          note_mismatch("basis_index", out_data.basis_index, want.basis_index);
        if (out_data.first_order !== want.first_order)
          note_mismatch("first_order", out_data.first_order, want.first_order);
        if (out_data.second_order !== want.second_order)
          note_mismatch("second_order", out_data.second_order, want.second_order);
        if (out_data.third_order !== want.third_order)
          note_mismatch("third_order", out_data.third_order, want.third_order);
        if (out_data.saturated !== want.saturated)
          note_mismatch("saturated", out_data.saturated, want.saturated);
        if (out_data.last !== want.last)
          note_mismatch("last", out_data.last, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: everything changes on the falling edge. push is computed once and
  // assigned once so a back-to-back transfer never glitches low.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : feed
    logic    nxt_push;
    lag_in_t nxt_data;
    if (rst_ni) begin
      nxt_push = push;
      nxt_data = in_data;
      if (!push || in_taken) begin
        nxt_push = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (queued_vars.size() > 0) begin
          nxt_data = queued_vars.pop_front();
          nxt_push = 1'b1;
          tx_gap   = tx_idle_on ? int'($urandom_range(0, 3)) : 0;
        end
      end
      push    <= nxt_push;
      in_data <= nxt_data;

      // receiver: fresh stall count after each transfer
      if (out_taken) rx_stall = rx_idle_on ? int'($urandom_range(0, 3)) : 0;
      if (rx_stall > 0) begin
        rx_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input val_t x0, input val_t x1, input val_t x2);
    lag_in_t it;
    it.first_var  = x0;
    it.second_var = x1;
    it.third_var  = x2;
    queued_vars.push_back(it);
    items_queued++;
  endtask

  // Mostly values near the polynomial roots, some wide and raw ones to hit
  // saturation and every input bit.
  function automatic val_t random_var();
    val_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = int'($urandom_range(0, 24 * 65536)) - 4 * 65536;
      5, 6:          v = $urandom;
      7:             v = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      8: begin
        case ($urandom_range(0, 5))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          3:       v = -1;
          4:       v = 1;
          default: v = 32'sh0001_0000;
        endcase
      end
      default:       v = $signed($urandom) >>> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  task automatic queue_random(input int count);
    for (int k = 0; k < count; k++) queue_item(random_var(), random_var(), random_var());
  endtask

  // Sender holds off until all queued items went in and every result came back.
  task automatic wait_for_quiet();
    while (queued_vars.size() != 0 || items_accepted != items_queued
           || pending_basis.size() != 0)
      @(negedge clk_i);
  endtask

  // Two-phase register write: setup, then access until pready.
  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_MAX_DEGREE) cfg_degree = value[ORD_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Degree register read-back; upper bits carry nothing, so only the code is checked.
  task automatic check_degree_reg();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_MAX_DEGREE, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[ORD_W-1:0] !== cfg_degree)
      note_mismatch("max_degree read-back", prdata[ORD_W-1:0], cfg_degree);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // degree code with random upper bits, which the register must mask off
  function automatic logic [CFG_W-1:0] degree_word(input int deg);
    return ($urandom & ~32'h7) | deg[2:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still expected",
             cycle_count, pending_basis.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int deg_plan [0:9];
    deg_plan = '{2, 4, 1, 7, 0, 3, 5, 4, 6, 3};

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;

    // Directed, reset degree (3): zero, unit steps, extremes, product overflow
    check_degree_reg();
    queue_item('0, '0, '0);
    queue_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    queue_item(32'sh7FFF_FFFF, 32'sh8000_0000, -1);
    queue_item(32'sh8000_0000, 32'sh7FFF_FFFF, '0);
    queue_item(-1, 1, 32'sh0001_0000);
    queue_item(32'sh0003_8000, 32'sh000A_0000, 32'shFFF6_0000);
    // L1 near 16385.0 each: the La*Lb step overflows on its own
    queue_item(32'shC000_0000, 32'shC000_0000, '0);
    wait_for_quiet();

    // Degree zero: a single constant result per item
    write_reg(REG_MAX_DEGREE, degree_word(0));
    check_degree_reg();
    queue_item(32'sh1234_5678, 32'shFEDC_BA98, 32'sh8000_0000);
    queue_item('0, -1, 32'sh7FFF_FFFF);
    wait_for_quiet();

    // Write to an unmapped slot: degree must stay zero
    write_reg(REG_SPARE, degree_word(2));
    check_degree_reg();
    queue_item(32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000);
    wait_for_quiet();

    // Unused code above the cap behaves as the top degree
    write_reg(REG_MAX_DEGREE, degree_word(7));
    check_degree_reg();
    queue_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    queue_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    queue_item(32'sh0000_8000, 32'sh0006_0000, 32'sh000C_8000);
    queue_item(32'shFFFF_0000, 32'sh0000_0001, 32'sh0010_0000);
    wait_for_quiet();

    write_reg(REG_MAX_DEGREE, degree_word(4));
    check_degree_reg();
    queue_item(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    queue_item(32'sh0040_0000, 32'shFFC0_0000, 32'sh0000_FFFF);
    queue_item(32'shFFFF_FFFF, 32'shAAAA_AAAA, 32'sh5555_5555);
    queue_item(32'sh0009_3333, 32'sh0004_8000, 32'sh0000_4000);
    wait_for_quiet();

    write_reg(REG_MAX_DEGREE, degree_word(1));
    check_degree_reg();
    queue_item(32'sh7FFF_FFFF, 32'sh8000_0000, '0);
    queue_item(32'sh8001_0000, 32'sh0001_0000, 32'sh7FFF_0000);
    wait_for_quiet();

    // Random phases, each under its own degree and idling mix
    for (int ph = 0; ph < 10; ph++) begin
      tx_idle_on = (ph % 3) != 1;
      rx_idle_on = (ph % 3) != 2;
      write_reg(REG_MAX_DEGREE, degree_word(deg_plan[ph]));
      if (ph == 5) write_reg(REG_SPARE, $urandom);
      check_degree_reg();
      queue_random(13);
      // one mid-phase hold-off until the block has fully drained
      if (ph == 3) wait_for_quiet();
      queue_random(13);
      wait_for_quiet();
    end

    // let any stray result surface before the verdict
    repeat (64) @(negedge clk_i);
    if (pending_basis.size() != 0)
      note_mismatch("expectations left over", pending_basis.size(), 0);

    $display("covered %0d items, %0d basis results (%0d saturated), degree codes 0..7",
             items_accepted, results_seen, sat_seen);
    $display("with random gaps and stalls; %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
